>>> rtl/core/epool_pkg.sv
`default_nettype none
package epool_pkg;

  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_WORD  = 3'd1;
  localparam logic [2:0] ACT_HALF  = 3'd2;
  localparam logic [2:0] ACT_BYTE  = 3'd3;
  localparam logic [2:0] ACT_RANGE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HWFAIL  = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  localparam logic [31:0] SEED_RESET = 32'h8B9F7A3D;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted item
    logic push_wr;    // write one pool byte
    logic pop_rd;     // read one pool byte
    logic mix;        // run the fallback mixer
    logic div_start;  // start the span divider
    logic div_step;   // one restoring division step
    logic finish;     // form the result
  } epool_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       room;      // at least four free slots
    logic       avail;     // at least four stored bytes
    logic       pow2;      // span is a power of two (or zero)
    logic [2:0] action;
  } epool_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/epool_ctrl.sv
`default_nettype none
module epool_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              out_free,
  input  wire epool_pkg::epool_sts_t sts,
  output epool_pkg::epool_cmd_t  cmd,
  output logic                   busy
);
  import epool_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_PUSH, S_POP, S_DIV, S_DONE} state_t;

  state_t     state_r;
  logic [5:0] cnt_r;
  logic       pool_r;
  logic       draw_req;

  // Word, half, byte and range requests all draw one word.
  assign draw_req = sts.action inside {ACT_WORD, ACT_HALF, ACT_BYTE, ACT_RANGE};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pool_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_fire) state_r <= S_DEC;
        S_DEC: begin
          cnt_r <= '0;
          pool_r <= sts.avail;
          if (sts.action == ACT_PUSH) state_r <= sts.room ? S_PUSH : S_DONE;
          else if (draw_req)
            state_r <= sts.avail ? S_POP : (sts.action == ACT_RANGE ? S_DIV : S_DONE);
          else state_r <= S_DONE;
        end
        S_PUSH: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd3) state_r <= S_DONE;
        end
        S_POP: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd4) begin
            cnt_r <= '0;
            state_r <= (sts.action == ACT_RANGE) ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd32) state_r <= S_DONE;
        end
        S_DONE: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load      = in_fire;
    cmd.push_wr   = (state_r == S_PUSH);
    cmd.pop_rd    = (state_r == S_POP) && (cnt_r < 6'd4);
    cmd.mix       = (state_r == S_DEC) && !sts.avail && draw_req;
    cmd.div_start = (state_r == S_DIV) && (cnt_r == 6'd0);
    cmd.div_step  = (state_r == S_DIV) && (cnt_r != 6'd0);
    cmd.finish    = (state_r == S_DONE) && out_free;
  end

  assign busy = (state_r != S_IDLE);

  ap_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_IDLE) else $error("finish did not return to idle");
  ap_push4: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && cnt_r == 6'd3) |=> state_r == S_DONE)
    else $error("push length wrong");
  ap_nofire: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire) else $error("accept while busy");
  ap_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> pool_r) else $error("pop without pool data");
endmodule
`default_nettype wire

>>> rtl/core/epool_dp.sv
`default_nettype none
module epool_dp #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire epool_pkg::epool_cmd_t cmd,
  input  wire logic [2:0]            action,
  input  wire logic [31:0]           entropy_word,
  input  wire logic                  entropy_ok,
  input  wire logic [31:0]           range_min,
  input  wire logic [31:0]           range_max,
  output epool_pkg::epool_sts_t      sts,
  output logic [31:0]                res_value,
  output logic [1:0]                 res_status,
  output logic                       res_from_pool,
  output logic [6:0]                 res_pool_level
);
  import epool_pkg::*;

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int PW = AW + 1;
  localparam logic [PW:0] DEPTH2 = (PW+1)'(2 * POOL_DEPTH);
  localparam logic [PW-1:0] DEPTH = PW'(POOL_DEPTH);

  logic [7:0]    mem [POOL_DEPTH];
  logic [7:0]    rd_q;
  logic [PW-1:0] rp_r, wp_r, level;
  logic [2:0]    act_r;
  logic [31:0]   ew_r, min_r, span_r, seed_r, w_r;
  logic          ok_r, pooled_r, pushed_r;
  logic [1:0]    bcnt_r;
  logic          rd_v_r;
  logic [31:0]   q_r, rem_r;
  logic [31:0]   x1, x2, x3, seed_nxt;
  logic [33:0]   trial;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    logic [PW:0] s;
    s = {1'b0, p} + 1'b1;
    if (s >= DEPTH2) s = s - DEPTH2;
    return s[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DEPTH) ? p - DEPTH : p;
    return s[AW-1:0];
  endfunction

  always_comb begin
    logic [PW:0] d;
    d = {1'b0, wp_r} + DEPTH2 - {1'b0, rp_r};
    if (d >= DEPTH2) d = d - DEPTH2;
    level = d[PW-1:0];
  end

  assign x1 = seed_r ^ (seed_r << 13);
  assign x2 = x1 ^ (x1 >> 17);
  assign x3 = x2 ^ (x2 << 5);
  assign seed_nxt = x3 + ew_r;

  assign sts.room   = (DEPTH - level) >= PW'(4);
  assign sts.avail  = level >= PW'(4);
  assign sts.pow2   = (span_r & (span_r - 32'd1)) == 32'd0;
  assign sts.action = act_r;

  always_ff @(posedge clk) begin
    if (cmd.push_wr) mem[slot(wp_r)] <= ew_r[8*bcnt_r +: 8];
    rd_q <= mem[slot(rp_r)];
  end

  // The partial remainder needs 33 bits before the compare.
  assign trial = {1'b0, rem_r, q_r[31]} - {2'b00, span_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0; wp_r <= '0; seed_r <= SEED_RESET;
      bcnt_r <= '0; rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.pop_rd;
      if (cmd.load) begin
        act_r <= action; ew_r <= entropy_word; ok_r <= entropy_ok;
        min_r <= range_min; span_r <= range_max - range_min + 32'd1;
        bcnt_r <= '0; pooled_r <= 1'b0; pushed_r <= 1'b0; w_r <= '0;
      end
      if (cmd.push_wr) begin
        wp_r <= inc(wp_r); bcnt_r <= bcnt_r + 2'd1; pushed_r <= 1'b1;
      end
      if (cmd.pop_rd) rp_r <= inc(rp_r);
      if (rd_v_r) begin
        w_r <= {rd_q, w_r[31:8]}; pooled_r <= 1'b1;
      end
      if (cmd.mix) begin
        if (ok_r) begin
          seed_r <= seed_nxt; w_r <= seed_nxt ^ ew_r;
        end else w_r <= '0;
      end
      if (cmd.div_start) begin
        q_r <= w_r; rem_r <= '0;
      end
      if (cmd.div_step) begin
        if (!trial[33]) rem_r <= trial[31:0];
        else rem_r <= {rem_r[30:0], q_r[31]};
        q_r <= {q_r[30:0], ~trial[33]};
      end
    end
  end

  // The divider leaves w mod span in rem_r. The draw lies below the largest
  // multiple of the span exactly when (w mod span) + (0xFFFFFFFF - w) reaches
  // the span.
  always_comb begin
    logic [32:0] tail;
    tail = {1'b0, rem_r} + {1'b0, ~w_r};
    res_value = '0; res_status = ST_OK;
    res_from_pool = pooled_r;
    res_pool_level = 7'(level);
    case (act_r)
      ACT_PUSH: if (!pushed_r) res_status = ST_DROPPED;
      ACT_WORD: res_value = w_r;
      ACT_HALF: res_value = w_r >> 16;
      ACT_BYTE: res_value = w_r >> 24;
      ACT_RANGE: begin
        if (sts.pow2) res_value = min_r + (w_r & (span_r - 32'd1));
        else if (tail < {1'b0, span_r}) res_status = ST_REJECT;
        else res_value = min_r + rem_r;
      end
      default: ;
    endcase
    if ((act_r == ACT_WORD || act_r == ACT_HALF || act_r == ACT_BYTE ||
         act_r == ACT_RANGE) && !pooled_r && !ok_r) res_status = ST_HWFAIL;
  end
endmodule
`default_nettype wire

>>> rtl/core/entropy_pool_random_word_server_core.sv
// A push writes four pool bytes when there is room; a pooled draw pops four
// bytes, a fallback draw runs the mixer, and a range draw then runs the
// 32-step restoring divider. One transaction is handled at a time: in_tready
// stays low until the controller returns to idle.
// Reset (rst_n low, synchronous) empties the pool, reloads the seed and
// returns the controller to idle; pool bytes are not cleared.
`default_nettype none
module entropy_pool_random_word_server_core #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,  // action[2:0], entropy_word, entropy_ok,
                                       // range_min, range_max, zero fill
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [47:0]       out_tdata   // value, status, from_pool, pool_level, zero
);
  import epool_pkg::*;

  epool_cmd_t  cmd;
  epool_sts_t  sts;
  logic        busy, in_fire, out_free;
  logic [31:0] rv;
  logic [1:0]  rs;
  logic        rp;
  logic [6:0]  rl;
  logic [47:0] out_r;
  logic        outv_r;

  // The output register frees once its transaction is taken.
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !outv_r || out_tready;

  epool_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .busy
  );

  epool_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk, .rst_n, .cmd,
    .action(in_tdata[2:0]), .entropy_word(in_tdata[34:3]), .entropy_ok(in_tdata[35]),
    .range_min(in_tdata[67:36]), .range_max(in_tdata[99:68]), .sts,
    .res_value(rv), .res_status(rs), .res_from_pool(rp), .res_pool_level(rl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) outv_r <= 1'b0;
    else if (cmd.finish) outv_r <= 1'b1;
    else if (out_tready) outv_r <= 1'b0;
    if (cmd.finish) out_r <= {6'd0, rl, rp, rs, rv};
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = out_r;
endmodule
`default_nettype wire
